/* rtl/dmvm_pkg.sv */
// ----------------------------------------------------------------------------
// dmvm_pkg
// Shared types and constants for the dense matrix-vector multiply block.
// ----------------------------------------------------------------------------
package dmvm_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned POS_W        = 11;
  localparam int unsigned ROW_W        = 16;
  localparam int unsigned MAX_COLS_DEF = 1024;
  localparam int unsigned FIFO_DEF     = 4;

  localparam logic [POS_W-1:0] COLS_RESET = POS_W'(1024);

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_MATRIX = 1'b1
  } op_e;

  // One matrix element with its vector operand, on its way to the datapath.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] elem;
    logic              last;
    logic [ROW_W-1:0]  row;
  } item_t;

endpackage

/* rtl/dmvm_front.sv */
// ----------------------------------------------------------------------------
// dmvm_front
// Takes input beats, keeps the vector store and the load, column and row
// positions, and hands each matrix element with its operand to the queue.
// ----------------------------------------------------------------------------
module dmvm_front #(
  parameter int unsigned MAX_COLS = dmvm_pkg::MAX_COLS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dmvm_pkg::POS_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [dmvm_pkg::DATA_W-1:0]  value_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output dmvm_pkg::item_t              push_item_o
);
  import dmvm_pkg::*;

  localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned NW = ($clog2(MAX_COLS + 1) > POS_W) ?
                               $clog2(MAX_COLS + 1) : POS_W;

  logic [POS_W-1:0]  cols_q;
  logic [POS_W-1:0]  load_pos_q, load_pos_d;
  logic [POS_W-1:0]  col_pos_q, col_pos_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              s1_valid_q, s1_valid_d;
  logic [DATA_W-1:0] s1_value_q;
  logic              s1_last_q;
  logic [ROW_W-1:0]  s1_row_q;
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] mem [MAX_COLS];

  logic [NW-1:0] cols_ext, n_eff, lpos, lnext, cnext;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          accept, ld, mx, last;

  // Effective column count: zero acts as one, and it is capped at the store depth.
  always_comb begin
    cols_ext = NW'(cols_q);
    if (cols_ext == '0) begin
      n_eff = NW'(1);
    end else if (cols_ext > NW'(MAX_COLS)) begin
      n_eff = NW'(MAX_COLS);
    end else begin
      n_eff = cols_ext;
    end
  end

  always_comb begin
    lpos = NW'(load_pos_q);
    if (lpos >= n_eff) begin
      lpos = '0;
    end
    lnext = lpos + NW'(1);
    if (lnext >= n_eff) begin
      lnext = '0;
    end
    cnext = NW'(col_pos_q) + NW'(1);
    last  = (cnext >= n_eff);
  end

  assign wr_addr     = AW'(lpos);
  assign rd_addr     = AW'(col_pos_q);
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !s1_valid_q || push_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign ld          = accept && (opcode_i == OP_LOAD);
  assign mx          = accept && (opcode_i == OP_MATRIX);

  always_comb begin
    load_pos_d = load_pos_q;
    col_pos_d  = col_pos_q;
    row_d      = row_q;
    if (ld) begin
      load_pos_d = POS_W'(lnext);
    end
    if (mx) begin
      if (last) begin
        col_pos_d = '0;
        row_d     = row_q + ROW_W'(1);
      end else begin
        col_pos_d = POS_W'(cnext);
      end
    end
    s1_valid_d = mx || (s1_valid_q && !push_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= COLS_RESET;
      load_pos_q <= '0;
      col_pos_q  <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cols_q <= cfg_data_i;
      end
      load_pos_q <= load_pos_d;
      col_pos_q  <= col_pos_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // Vector store. A load in one cycle is seen by a matrix read in the next.
  always_ff @(posedge clk_i) begin
    if (ld) begin
      mem[wr_addr] <= value_i;
    end
    if (mx) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mx) begin
      s1_value_q <= value_i;
      s1_last_q  <= last;
      s1_row_q   <= row_q;
    end
  end

  assign push_valid_o = s1_valid_q;
  always_comb begin
    push_item_o.value = s1_value_q;
    push_item_o.elem  = rd_q;
    push_item_o.last  = s1_last_q;
    push_item_o.row   = s1_row_q;
  end

endmodule

/* rtl/dmvm_fifo.sv */
// ----------------------------------------------------------------------------
// dmvm_fifo
// Short queue of matrix elements between the front end and the datapath.
// ----------------------------------------------------------------------------
module dmvm_fifo #(
  parameter int unsigned DEPTH = dmvm_pkg::FIFO_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  dmvm_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output dmvm_pkg::item_t pop_item_o
);
  import dmvm_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

/* rtl/dmvm_back.sv */
// ----------------------------------------------------------------------------
// dmvm_back
// Multiply-accumulate datapath: one registered product stage, the running
// sum and the result register.
// ----------------------------------------------------------------------------
module dmvm_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               pop_valid_i,
  output logic                               pop_ready_o,
  input  dmvm_pkg::item_t                    pop_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dmvm_pkg::ROW_W-1:0]         row_index_o,
  output logic signed [dmvm_pkg::DATA_W-1:0] row_sum_o
);
  import dmvm_pkg::*;

  logic                m_valid_q, m_valid_d;
  logic [DATA_W-1:0]   m_prod_q;
  logic                m_last_q;
  logic [ROW_W-1:0]    m_row_q;
  logic [DATA_W-1:0]   acc_q, acc_d;
  logic                out_valid_q, out_valid_d;
  logic [ROW_W-1:0]    out_row_q;
  logic [DATA_W-1:0]   out_sum_q;
  logic [2*DATA_W-1:0] mult_full;
  logic [DATA_W-1:0]   sum;
  logic                m_ready, pop, consume, out_fire;

  // Only the low word of the product matters, as the sum wraps at 32 bits.
  assign mult_full = pop_item_i.value * pop_item_i.elem;
  assign sum       = acc_q + m_prod_q;

  assign m_ready     = !m_last_q || !out_valid_q || out_ready_i;
  assign pop_ready_o = !m_valid_q || m_ready;
  assign pop         = pop_valid_i && pop_ready_o;
  assign consume     = m_valid_q && m_ready;
  assign out_fire    = consume && m_last_q;

  always_comb begin
    m_valid_d   = pop || (m_valid_q && !m_ready);
    out_valid_d = out_fire || (out_valid_q && !out_ready_i);
    acc_d       = acc_q;
    if (consume) begin
      acc_d = m_last_q ? '0 : sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      m_valid_q   <= m_valid_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      m_prod_q <= mult_full[DATA_W-1:0];
      m_last_q <= pop_item_i.last;
      m_row_q  <= pop_item_i.row;
    end
    if (out_fire) begin
      out_row_q <= m_row_q;
      out_sum_q <= sum;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_index_o = out_row_q;
  assign row_sum_o   = signed'(out_sum_q);

endmodule

/* rtl/dense_matrix_vector_multiply.sv */
// ----------------------------------------------------------------------------
// dense_matrix_vector_multiply
// Integer matrix-vector product engine with a streaming row-major input.
// ----------------------------------------------------------------------------
// Usage: the input channel carries beats of (opcode_i, value_i). A load beat
// writes the next vector element into the on-chip store; a matrix beat is
// multiplied by the stored element for its column and added to the row sum.
// After cols_in_use matrix beats (zero counts as one; capped at MAX_COLS) a
// result beat (row_index_o, row_sum_o) appears on the output channel, and
// the sum restarts from zero. The configuration channel writes cols_in_use;
// write it only while idle. Throughput: one input beat per cycle, sustained,
// including back-to-back loads and matrix elements, while results are taken.
// The last matrix beat of a row passes the store read, queue, product
// register and result register before its result beat becomes valid.
// Reset clears the positions, row counter and sum, and sets cols_in_use to
// 1024; the vector store holds no defined data until it has been loaded.
// When the receiver stalls, the result register holds its beat, the product
// stage and the queue fill, and only then does in_ready_o fall.
// ----------------------------------------------------------------------------
module dense_matrix_vector_multiply #(
  parameter int unsigned MAX_COLS   = dmvm_pkg::MAX_COLS_DEF,
  parameter int unsigned FIFO_DEPTH = dmvm_pkg::FIFO_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dmvm_pkg::POS_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               opcode_i,
  input  logic signed [dmvm_pkg::DATA_W-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dmvm_pkg::ROW_W-1:0]         row_index_o,
  output logic signed [dmvm_pkg::DATA_W-1:0] row_sum_o
);
  import dmvm_pkg::*;

  // Front end to queue.
  logic  push_valid, push_ready;
  item_t push_item;
  // Queue to datapath.
  logic  pop_valid, pop_ready;
  item_t pop_item;

  // The front end owns the configuration register and the vector store, so
  // loads and matrix reads stay in input order without any forwarding.
  dmvm_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .value_i      (unsigned'(value_i)),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // The queue lets the front keep taking beats while a result is stalled.
  dmvm_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // The datapath multiplies, accumulates and presents finished rows.
  dmvm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_index_o (row_index_o),
    .row_sum_o   (row_sum_o)
  );

endmodule
